@@ rtl/qsps_pkg.sv @@
// Shared types, character codes and the hex digit decoder for the query splitter.
`default_nettype none

package qsps_pkg;

  // Result kinds as seen on the output port
  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_VALUE   = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_DISCARD = 2'd3
  } kind_e;

  // Percent-escape progress
  typedef enum logic [1:0] {
    ESC_NONE   = 2'd0,
    ESC_FIRST  = 2'd1,
    ESC_SECOND = 2'd2
  } esc_e;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  // Work for the back end from one request: an optional decoded byte,
  // then an optional end or discard mark.
  typedef struct packed {
    logic        has_data;
    kind_e       data_kind;
    logic [7:0]  data_byte;
    logic        has_mark;
    kind_e       mark_kind;
  } cmd_t;

  // One result item
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        run_end;
  } res_t;

  // Returns {valid, nibble}; nibble is zero for a non-hex character
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/qsps_front.sv @@
// Front end: accepts query bytes, tracks name/value and escape state, builds commands.
`default_nettype none

module qsps_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire logic [7:0]     query_byte_i,
  input  wire logic           is_last_i,
  input  wire logic           cmd_full_i,
  output qsps_pkg::cmd_t      cmd_o,
  output logic                cmd_push_o
);

  logic                 in_value_q, in_value_d;
  qsps_pkg::esc_e       esc_q, esc_d;
  logic [3:0]           nib_q, nib_d;
  logic                 nib_valid_q, nib_valid_d;
  logic                 accept;
  logic [4:0]           hex;
  qsps_pkg::kind_e      seg_kind;

  assign accept   = push_i && !cmd_full_i;
  assign hex      = qsps_pkg::hex_digit(query_byte_i);
  assign seg_kind = in_value_q ? qsps_pkg::KIND_VALUE : qsps_pkg::KIND_NAME;

  // Classify the byte and work out the next parser state
  always_comb begin
    cmd_o       = '0;
    in_value_d  = in_value_q;
    esc_d       = esc_q;
    nib_d       = nib_q;
    nib_valid_d = nib_valid_q;
    if (query_byte_i == qsps_pkg::CH_AMP) begin
      esc_d           = qsps_pkg::ESC_NONE;
      in_value_d      = 1'b0;
      cmd_o.has_mark  = 1'b1;
      cmd_o.mark_kind = qsps_pkg::KIND_DONE;
    end else if (query_byte_i == qsps_pkg::CH_EQ && !in_value_q) begin
      esc_d           = qsps_pkg::ESC_NONE;
      in_value_d      = 1'b1;
      cmd_o.has_mark  = is_last_i;
      cmd_o.mark_kind = qsps_pkg::KIND_DISCARD;
    end else begin
      cmd_o.data_kind = seg_kind;
      case (esc_q)
        qsps_pkg::ESC_FIRST: begin
          nib_valid_d = hex[4];
          nib_d       = hex[3:0];
          esc_d       = qsps_pkg::ESC_SECOND;
        end
        qsps_pkg::ESC_SECOND: begin
          cmd_o.has_data = 1'b1;
          if (!nib_valid_q) begin
            cmd_o.data_byte = 8'd0;
          end else if (hex[4]) begin
            cmd_o.data_byte = {nib_q, hex[3:0]};
          end else begin
            cmd_o.data_byte = {4'd0, nib_q};
          end
          esc_d = qsps_pkg::ESC_NONE;
        end
        default: begin
          esc_d = qsps_pkg::ESC_NONE;
          if (query_byte_i == qsps_pkg::CH_PLUS) begin
            cmd_o.has_data  = 1'b1;
            cmd_o.data_byte = qsps_pkg::CH_SPACE;
          end else if (query_byte_i == qsps_pkg::CH_PCT) begin
            esc_d = qsps_pkg::ESC_FIRST;
          end else begin
            cmd_o.has_data  = 1'b1;
            cmd_o.data_byte = query_byte_i;
          end
        end
      endcase
      cmd_o.has_mark  = is_last_i;
      cmd_o.mark_kind = qsps_pkg::KIND_DONE;
    end
    // Final byte returns the parser to its idle state
    if (is_last_i) begin
      in_value_d  = 1'b0;
      esc_d       = qsps_pkg::ESC_NONE;
      nib_d       = 4'd0;
      nib_valid_d = 1'b0;
    end
  end

  assign cmd_push_o = accept && (cmd_o.has_data || cmd_o.has_mark);

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_value_q  <= 1'b0;
      esc_q       <= qsps_pkg::ESC_NONE;
      nib_q       <= 4'd0;
      nib_valid_q <= 1'b0;
    end else if (accept) begin
      in_value_q  <= in_value_d;
      esc_q       <= esc_d;
      nib_q       <= nib_d;
      nib_valid_q <= nib_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/qsps_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
`default_nettype none

module qsps_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire qsps_pkg::cmd_t cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output qsps_pkg::cmd_t      head_o,
  output logic                empty_o
);

  qsps_pkg::cmd_t                   mem_q [qsps_pkg::CmdDepth];
  logic [qsps_pkg::CmdPtrW-1:0]     wr_q, rd_q;
  logic [qsps_pkg::CmdCntW-1:0]     cnt_q;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == qsps_pkg::CmdCntW'(qsps_pkg::CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/qsps_back.sv @@
// Back end: expands commands into result items and holds them in a two-entry output queue.
`default_nettype none

module qsps_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire qsps_pkg::cmd_t cmd_i,
  input  wire logic           cmd_empty_i,
  output logic                cmd_pop_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output qsps_pkg::res_t      res_o
);

  logic                 sent_data_q, sent_data_d;
  qsps_pkg::res_t       buf_q [2];
  logic                 wr_q, rd_q;
  logic [1:0]           cnt_q;
  logic                 emit, last_part, do_pop;
  qsps_pkg::res_t       res_new;

  // Pick the next result of the head command
  always_comb begin
    res_new = '0;
    if (cmd_i.has_data && !sent_data_q) begin
      res_new.kind    = cmd_i.data_kind;
      res_new.data    = cmd_i.data_byte;
      res_new.run_end = !cmd_i.has_mark;
    end else begin
      res_new.kind    = cmd_i.mark_kind;
      res_new.run_end = 1'b1;
    end
  end

  assign emit        = !cmd_empty_i && (cnt_q != 2'd2);
  assign last_part   = res_new.run_end;
  assign cmd_pop_o   = emit && last_part;
  assign sent_data_d = cmd_pop_o ? 1'b0 : (emit ? 1'b1 : sent_data_q);

  assign empty_o = (cnt_q == 2'd0);
  assign do_pop  = pop_i && !empty_o;
  assign res_o   = buf_q[rd_q];

  // Output queue storage
  always_ff @(posedge clk_i) begin
    if (emit) begin
      buf_q[wr_q] <= res_new;
    end
  end

  // Expansion progress and output queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_data_q <= 1'b0;
      wr_q        <= 1'b0;
      rd_q        <= 1'b0;
      cnt_q       <= 2'd0;
    end else begin
      sent_data_q <= sent_data_d;
      if (emit)   wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      if (emit && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !emit) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/query_string_param_splitter_unit.sv @@
// Top level of the query string parameter splitter.
`default_nettype none

// Splits a URL query string, one raw byte per request, into name and value
// bytes with '+' and %XY decoding, followed by a parameter-complete mark on
// '&' or the last byte, or a discard mark when the query ends right after a
// name's '='. One byte is taken every clock cycle while full is low; each
// byte yields zero, one or two results, and the result side delivers at most
// one result per cycle, so the two results of a byte come out one after the
// other. A four-entry command queue between the parser front end and the
// result expander absorbs such bursts, and a two-entry output queue keeps
// the expander running while a result waits to be popped. A byte's command
// enters the command queue on the edge that accepts it; its first result is
// then registered into the output queue, which drives the ports, once it has room.
module query_string_param_splitter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  query_byte_i,
  input  wire logic        is_last_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind_o,
  output logic [7:0]       out_byte_o,
  output logic             run_end_o
);

  qsps_pkg::cmd_t  cmd_in, cmd_head;
  logic            cmd_push, cmd_full, cmd_pop, cmd_empty;
  qsps_pkg::res_t  res;

  qsps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .query_byte_i (query_byte_i),
    .is_last_i    (is_last_i),
    .cmd_full_i   (cmd_full),
    .cmd_o        (cmd_in),
    .cmd_push_o   (cmd_push)
  );

  qsps_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .head_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  qsps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign full       = cmd_full;
  assign kind_o     = res.kind;
  assign out_byte_o = res.data;
  assign run_end_o  = res.run_end;

endmodule

`default_nettype wire

@@ sim/tb_query_string_param_splitter_unit.sv @@
// Self-checking testbench for the query string parameter splitter.
`timescale 1ns / 100ps

module tb_query_string_param_splitter_unit;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_LEN       = 300;
  localparam int unsigned PHASE_BYTES    = 250;
  localparam int unsigned TAIL_CYCLES    = 8;

  // One raw query byte waiting to be offered
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } query_req_t;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       push       = 1'b0;
  logic [7:0] query_byte = 8'h00;
  logic       is_last    = 1'b0;
  logic       pop        = 1'b0;
  logic       full;
  logic       empty;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic       run_end_o;

  query_req_t      query_bytes_todo[$];
  qsps_pkg::res_t  split_results_due[$];
  logic [7:0]      query_text[$];
  query_req_t      next_req;
  int unsigned     bytes_queued   = 0;
  int unsigned     mismatch_count = 0;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_idle_pct  = 0;
  int unsigned     idle_cycles    = 0;
  int unsigned     hold_cycles    = 0;
  logic            hold_armed     = 1'b0;
  logic            recv_hold;

  // Predictor copy of the parser state
  logic             in_value_part;
  qsps_pkg::esc_e   pct_phase;
  logic [3:0]       first_nibble;
  logic             first_nibble_ok;
  logic             segment_has_bytes;

  query_string_param_splitter_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .query_byte_i (query_byte),
    .is_last_i    (is_last),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
    logic ok;
    ok = 1'b1;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
    end else begin
      v  = 4'h0;
      ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic clear_parser_state();
    in_value_part     = 1'b0;
    pct_phase         = qsps_pkg::ESC_NONE;
    first_nibble      = 4'h0;
    first_nibble_ok   = 1'b0;
    segment_has_bytes = 1'b0;
  endtask

  // Works out the results of one accepted query byte and queues them
  task automatic split_query_byte(input logic [7:0] b, input logic last);
    qsps_pkg::res_t   found[2];
    int               n;
    qsps_pkg::kind_e  data_kind;
    logic [3:0]       nib;
    n = 0;
    if (b == qsps_pkg::CH_AMP) begin
      pct_phase         = qsps_pkg::ESC_NONE;
      in_value_part     = 1'b0;
      segment_has_bytes = 1'b0;
      found[n] = '{kind: qsps_pkg::KIND_DONE, data: 8'h00, run_end: 1'b0};
      n++;
    end else if (b == qsps_pkg::CH_EQ && !in_value_part) begin
      pct_phase         = qsps_pkg::ESC_NONE;
      in_value_part     = 1'b1;
      segment_has_bytes = 1'b0;
      if (last) begin
        found[n] = '{kind: qsps_pkg::KIND_DISCARD, data: 8'h00, run_end: 1'b0};
        n++;
      end
    end else begin
      data_kind         = in_value_part ? qsps_pkg::KIND_VALUE : qsps_pkg::KIND_NAME;
      segment_has_bytes = 1'b1;
      case (pct_phase)
        qsps_pkg::ESC_FIRST: begin
          first_nibble_ok = hex_nibble(b, first_nibble);
          pct_phase       = qsps_pkg::ESC_SECOND;
        end
        qsps_pkg::ESC_SECOND: begin
          pct_phase = qsps_pkg::ESC_NONE;
          found[n]  = '{kind: data_kind, data: 8'h00, run_end: 1'b0};
          // bad first digit gives zero, bad second digit keeps the first
          if (first_nibble_ok) begin
            if (hex_nibble(b, nib)) begin
              found[n].data = {first_nibble, nib};
            end else begin
              found[n].data = {4'h0, first_nibble};
            end
          end
          n++;
        end
        default: begin
          pct_phase = qsps_pkg::ESC_NONE;
          if (b == qsps_pkg::CH_PLUS) begin
            found[n] = '{kind: data_kind, data: qsps_pkg::CH_SPACE, run_end: 1'b0};
            n++;
          end else if (b == qsps_pkg::CH_PCT) begin
            pct_phase = qsps_pkg::ESC_FIRST;
          end else begin
            found[n] = '{kind: data_kind, data: b, run_end: 1'b0};
            n++;
          end
        end
      endcase
      if (last) begin
        found[n] = '{kind: qsps_pkg::KIND_DONE, data: 8'h00, run_end: 1'b0};
        n++;
      end
    end
    if (last) begin
      clear_parser_state();
    end
    if (n > 0) begin
      found[n-1].run_end = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      split_results_due.push_back(found[i]);
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic queue_byte(input logic [7:0] b, input logic last);
    query_bytes_todo.push_back('{data: b, last: last});
    bytes_queued++;
  endtask

  function automatic logic [7:0] pick_hex_char();
    int unsigned v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'("0" + v);
    if (v < 16) return 8'("a" + v - 10);
    return 8'("A" + v - 16);
  endfunction

  function automatic logic [7:0] pick_alnum();
    int unsigned v;
    v = $urandom_range(0, 61);
    if (v < 10) return 8'("0" + v);
    if (v < 36) return 8'("a" + v - 10);
    return 8'("A" + v - 36);
  endfunction

  // Any byte that does not split the current segment
  function automatic logic [7:0] pick_plain_byte(input logic value_part);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == qsps_pkg::CH_AMP || (!value_part && b == qsps_pkg::CH_EQ));
    return b;
  endfunction

  // Appends one piece of name or value text, possibly an escape
  task automatic add_text(input logic value_part);
    case ($urandom_range(0, 9))
      5: query_text.push_back(qsps_pkg::CH_PLUS);
      6: begin
        query_text.push_back(qsps_pkg::CH_PCT);
        query_text.push_back(pick_hex_char());
        query_text.push_back(pick_hex_char());
      end
      7: begin
        query_text.push_back(qsps_pkg::CH_PCT);
        query_text.push_back(pick_plain_byte(value_part));
        query_text.push_back($urandom_range(0, 1) ? pick_hex_char()
                                                  : pick_plain_byte(value_part));
      end
      8: query_text.push_back(pick_plain_byte(value_part));
      9: query_text.push_back(qsps_pkg::CH_PCT);
      default: query_text.push_back(pick_alnum());
    endcase
  endtask

  // Mostly well-formed queries with random content, some raw noise
  task automatic queue_random_bytes(input int unsigned count);
    int unsigned target;
    int unsigned nparam;
    target = bytes_queued + count;
    while (bytes_queued < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
      end else begin
        query_text.delete();
        nparam = $urandom_range(1, 4);
        for (int p = 0; p < nparam; p++) begin
          repeat ($urandom_range(0, 4)) add_text(1'b0);
          if ($urandom_range(0, 4) != 0) begin
            query_text.push_back(qsps_pkg::CH_EQ);
            repeat ($urandom_range(0, 5)) add_text(1'b1);
          end
          if (p + 1 < nparam || $urandom_range(0, 7) == 0) begin
            query_text.push_back(qsps_pkg::CH_AMP);
          end
        end
        if (query_text.size() == 0) begin
          query_text.push_back(pick_alnum());
        end
        foreach (query_text[i]) begin
          queue_byte(query_text[i], i == query_text.size() - 1);
        end
      end
    end
  endtask

  task automatic queue_directed();
    queue_byte(qsps_pkg::CH_PLUS, 1'b0);        // plus decodes to space
    queue_byte(qsps_pkg::CH_PCT, 1'b0);         // upper hex pair
    queue_byte("4", 1'b0);
    queue_byte("1", 1'b0);
    queue_byte(qsps_pkg::CH_PCT, 1'b0);         // bad first digit
    queue_byte(8'h00, 1'b0);
    queue_byte("1", 1'b0);
    queue_byte(qsps_pkg::CH_EQ, 1'b0);          // name to value
    queue_byte(qsps_pkg::CH_PCT, 1'b0);         // bad second digit
    queue_byte("a", 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(qsps_pkg::CH_EQ, 1'b0);          // later '=' is value data
    queue_byte(qsps_pkg::CH_PCT, 1'b0);         // '=' taken as escape digit
    queue_byte("F", 1'b0);
    queue_byte(qsps_pkg::CH_EQ, 1'b0);
    queue_byte(qsps_pkg::CH_AMP, 1'b0);
    queue_byte(qsps_pkg::CH_PCT, 1'b0);         // escape cut by '&'
    queue_byte(qsps_pkg::CH_AMP, 1'b0);
    queue_byte(qsps_pkg::CH_PCT, 1'b0);         // escape cut by name '='
    queue_byte(qsps_pkg::CH_EQ, 1'b0);
    queue_byte(qsps_pkg::CH_PCT, 1'b0);         // escape cut by end of query
    queue_byte("4", 1'b1);
    queue_byte("x", 1'b0);                      // query ends after '='
    queue_byte(qsps_pkg::CH_EQ, 1'b1);
    queue_byte(qsps_pkg::CH_AMP, 1'b1);         // final '&'
    queue_byte("q", 1'b1);                      // one-byte query
  endtask

  // Waits until every byte is taken and every result has come out
  task automatic drain();
    while (query_bytes_todo.size() != 0 || push || split_results_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result();
    qsps_pkg::res_t want;
    if (split_results_due.size() == 0) begin
      report_mismatch("result with nothing pending, kind", kind_o, -1);
    end else begin
      want = split_results_due.pop_front();
      if (kind_o !== want.kind) report_mismatch("kind", kind_o, want.kind);
      if (out_byte_o !== want.data) report_mismatch("out_byte", out_byte_o, want.data);
      if (run_end_o !== want.run_end) report_mismatch("run_end", run_end_o, want.run_end);
    end
  endtask

  // ---------------------------------------------------------------- processes

  // Request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (push) begin
        split_query_byte(query_byte, is_last);
      end
      if (query_bytes_todo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = query_bytes_todo.pop_front();
        push       <= 1'b1;
        query_byte <= next_req.data;
        is_last    <= next_req.last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here once armed
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_cycles <= 0;
    end else if (recv_hold) begin
      hold_cycles <= hold_cycles + 1;
    end
  end

  assign recv_hold = hold_armed && hold_cycles < HOLD_LEN;

  // Result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        check_result();
      end
      pop <= !recv_hold && $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  // Watchdog on cycles with no request or result taken
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("query_string_param_splitter_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    clear_parser_state();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 33;
    recv_idle_pct = 52;
    queue_directed();
    queue_random_bytes(PHASE_BYTES);
    drain();

    send_idle_pct = 52;
    recv_idle_pct = 33;
    queue_random_bytes(PHASE_BYTES);
    drain();

    // no idling; the receiver holds off first so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed    = 1'b1;
    queue_random_bytes(PHASE_BYTES);
    drain();

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("query_string_param_splitter_unit: match");
    end else begin
      $display("query_string_param_splitter_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ query_string_param_splitter_unit.f @@
rtl/qsps_pkg.sv
rtl/qsps_front.sv
rtl/qsps_cmd_fifo.sv
rtl/qsps_back.sv
rtl/query_string_param_splitter_unit.sv
sim/tb_query_string_param_splitter_unit.sv
